// ===== rtl/pvfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pvfa_pkg
// Shared codes, register offsets and address constants for the planar VRAM
// and font address register block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvfa_pkg;

    // Access kinds carried by the request channel.
    localparam logic [1:0] KIND_REG_WRITE = 2'd0;
    localparam logic [1:0] KIND_REG_READ  = 2'd1;
    localparam logic [1:0] KIND_WIN_WRITE = 2'd2;

    // Register offsets.
    localparam logic [14:0] REG_MIX       = 15'h00;
    localparam logic [14:0] REG_PLANES    = 15'h01;
    localparam logic [14:0] REG_PAGE      = 15'h03;
    localparam logic [14:0] REG_JIS_HIGH  = 15'h14;
    localparam logic [14:0] REG_JIS_LOW   = 15'h15;
    localparam logic [14:0] REG_FONT_LEFT = 15'h16;
    localparam logic [14:0] REG_FONT_RIGHT = 15'h17;
    localparam logic [14:0] REG_ROM_EN    = 15'h19;

    // Address bases.
    localparam logic [19:0] RAM_WIN_BASE = 20'hc0000;
    localparam logic [19:0] RAM_REG_BASE = 20'hcff80;
    localparam logic [20:0] ROM_BASE     = 21'h180000;
    localparam logic [7:0]  PAGE_READ_VALUE = 8'h10;

    // Font offset computation.
    localparam logic [6:0]  JIS_LOW_BIAS    = 7'h20;
    localparam logic [6:0]  JIS_BAND1_LOW   = 7'h30;
    localparam logic [6:0]  JIS_BAND2_LOW   = 7'h70;
    localparam logic [11:0] FONT_ROW_STEP   = 12'hc00;
    localparam logic [17:0] FONT_BAND1_BASE = 18'h08000;
    localparam logic [17:0] FONT_BAND2_BASE = 18'h38000;

    // One result item.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        rom_read;
        logic [20:0] rom_address;
        logic        ram_access;
        logic        ram_write;
        logic [19:0] ram_address;
        logic        vram_write;
        logic [15:0] vram_word_address;
        logic [31:0] vram_data;
        logic [31:0] vram_bit_mask;
    } pvfa_rsp_t;

endpackage

// ===== rtl/pvfa_req_if.sv =====
// ----------------------------------------------------------------------------
// pvfa_req_if
// Request channel: one bus access per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvfa_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [14:0] offset;
    logic [7:0]  data;

    modport source (output valid, output kind, output offset, output data, input ready);
    modport sink   (input valid, input kind, input offset, input data, output ready);
endinterface

// ===== rtl/pvfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// pvfa_rsp_if
// Result channel: decoded outcome of one bus access per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pvfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic        rom_read;
    logic [20:0] rom_address;
    logic        ram_access;
    logic        ram_write;
    logic [19:0] ram_address;
    logic        vram_write;
    logic [15:0] vram_word_address;
    logic [31:0] vram_data;
    logic [31:0] vram_bit_mask;

    modport source (
        output valid, output read_data, output rom_read, output rom_address,
        output ram_access, output ram_write, output ram_address, output vram_write,
        output vram_word_address, output vram_data, output vram_bit_mask,
        input ready
    );
    modport sink (
        input valid, input read_data, input rom_read, input rom_address,
        input ram_access, input ram_write, input ram_address, input vram_write,
        input vram_word_address, input vram_data, input vram_bit_mask,
        output ready
    );
endinterface

// ===== rtl/pvfa_font_ofs.sv =====
// ----------------------------------------------------------------------------
// pvfa_font_ofs
// Maps a JIS code pair to a 17-bit font offset in one of three row bands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvfa_font_ofs
    import pvfa_pkg::*;
(
    input  logic [6:0]  jis_high,
    input  logic [6:0]  jis_low,
    output logic [16:0] font_offset
);

    logic [6:0]  low_m;
    logic [6:0]  high_m;
    logic [16:0] outer_ofs;
    logic [14:0] mid_low;
    logic [18:0] mid_row;
    logic [17:0] mid_sum;

    assign low_m  = jis_low - JIS_LOW_BIAS;
    assign high_m = jis_high - JIS_BAND1_LOW;

    // The outer bands share one bit layout; the top band adds a fixed base.
    assign outer_ofs = {3'b000, low_m[5], low_m[6], jis_high[2:0], jis_low[4:0], 4'b0000};

    // Middle band: the fields do not overlap, so only the row term needs a real add.
    assign mid_low = {low_m[6:5], jis_high[3:0], jis_low[4:0], 4'b0000};
    assign mid_row = 19'({high_m[6:4], 4'b0000}) * 19'(FONT_ROW_STEP);
    assign mid_sum = 18'(mid_low) + mid_row[17:0] + FONT_BAND1_BASE;

    always_comb
    begin
        if (jis_high < JIS_BAND1_LOW)
        begin
            font_offset = outer_ofs;
        end
        else if (jis_high < JIS_BAND2_LOW)
        begin
            font_offset = mid_sum[16:0];
        end
        else
        begin
            font_offset = outer_ofs | FONT_BAND2_BASE[16:0];
        end
    end

endmodule

// ===== rtl/planar_vram_and_font_address_regs_top.sv =====
// ----------------------------------------------------------------------------
// planar_vram_and_font_address_regs_top
// Register file and address mapper for a planar graphics window and font ROM.
// ----------------------------------------------------------------------------
// Usage:
//   Bus accesses arrive on the req channel (kind, offset, data); each transfer
//   produces exactly one item on the rsp channel carrying register read data,
//   a font ROM address, a redirected main RAM access or a masked VRAM word
//   write. Fields that do not apply to an access are zero.
//   cfg_we/cfg_wdata set main-memory mode; write it only while the block is
//   idle.
//   A req transfer reaches rsp valid through the input register, then the
//   decode and register update feeding the result register. One access is
//   accepted per cycle unless rsp stalls; the rate is set by the single decode
//   stage, where register state updates in the same cycle the result is formed.
//   When the receiver stalls, the result register holds its item, the input
//   register holds one more, and req.ready drops only once both are full.
//   Reset clears the register file, the mode bit and both pipeline valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module planar_vram_and_font_address_regs_top
    import pvfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    pvfa_req_if.sink    req,
    pvfa_rsp_if.source  rsp
);

    logic        mode_reg;

    logic        s1_valid_reg;
    logic [1:0]  s1_kind_reg;
    logic [14:0] s1_offset_reg;
    logic [7:0]  s1_data_reg;

    logic        out_valid_reg;
    pvfa_rsp_t   out_reg;
    pvfa_rsp_t   out_next;

    logic [3:0]  write_planes_reg, write_planes_next;
    logic [1:0]  read_plane_reg, read_plane_next;
    logic        page_select_reg, page_select_next;
    logic [7:0]  mix_value_reg, mix_value_next;
    logic        font_rom_enable_reg, font_rom_enable_next;
    logic [6:0]  jis_high_reg, jis_high_next;
    logic [6:0]  jis_low_reg, jis_low_next;
    logic [16:0] font_offset_reg, font_offset_next;

    logic [16:0] computed_ofs;
    logic [7:0]  mask_byte;
    logic        s1_advance;
    logic        in_take;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready  = !s1_valid_reg || s1_advance;
    assign in_take    = req.valid && req.ready;

    // The new JIS low byte is used together with the stored high byte.
    pvfa_font_ofs u_font_ofs (
        .jis_high    (jis_high_reg),
        .jis_low     (s1_data_reg[6:0]),
        .font_offset (computed_ofs)
    );

    assign mask_byte = {write_planes_reg, write_planes_reg};

    always_comb
    begin
        out_next             = '0;
        write_planes_next    = write_planes_reg;
        read_plane_next      = read_plane_reg;
        page_select_next     = page_select_reg;
        mix_value_next       = mix_value_reg;
        font_rom_enable_next = font_rom_enable_reg;
        jis_high_next        = jis_high_reg;
        jis_low_next         = jis_low_reg;
        font_offset_next     = font_offset_reg;

        case (s1_kind_reg)
            KIND_REG_WRITE, KIND_REG_READ:
            begin
                if (mode_reg)
                begin
                    out_next.ram_access  = 1'b1;
                    out_next.ram_write   = (s1_kind_reg == KIND_REG_WRITE);
                    out_next.ram_address = 20'(s1_offset_reg) + RAM_REG_BASE;
                end
                else if (s1_kind_reg == KIND_REG_WRITE)
                begin
                    case (s1_offset_reg)
                        REG_MIX:      mix_value_next = s1_data_reg;
                        REG_PLANES:
                        begin
                            write_planes_next = s1_data_reg[3:0];
                            read_plane_next   = s1_data_reg[7:6];
                        end
                        REG_PAGE:     page_select_next = s1_data_reg[4];
                        REG_JIS_HIGH: jis_high_next = s1_data_reg[6:0];
                        REG_JIS_LOW:
                        begin
                            jis_low_next     = s1_data_reg[6:0];
                            font_offset_next = computed_ofs;
                        end
                        REG_ROM_EN:   font_rom_enable_next = s1_data_reg[0];
                        default:      ;
                    endcase
                end
                else
                begin
                    case (s1_offset_reg)
                        REG_MIX:    out_next.read_data = mix_value_reg;
                        REG_PLANES: out_next.read_data = {read_plane_reg, 2'b00,
                                                          write_planes_reg};
                        REG_PAGE:   out_next.read_data = page_select_reg ? PAGE_READ_VALUE
                                                                         : 8'h00;
                        REG_FONT_LEFT:
                        begin
                            out_next.rom_read    = 1'b1;
                            out_next.rom_address = ROM_BASE + {3'b000, font_offset_reg, 1'b0};
                        end
                        REG_FONT_RIGHT:
                        begin
                            out_next.rom_read    = 1'b1;
                            out_next.rom_address = ROM_BASE + {3'b000, font_offset_reg, 1'b1};
                            font_offset_next     = font_offset_reg + 17'd1;
                        end
                        REG_ROM_EN: out_next.read_data = {7'b0000000, font_rom_enable_reg};
                        default:    ;
                    endcase
                end
            end
            KIND_WIN_WRITE:
            begin
                if (mode_reg)
                begin
                    out_next.ram_access  = 1'b1;
                    out_next.ram_write   = 1'b1;
                    out_next.ram_address = 20'(s1_offset_reg) + RAM_WIN_BASE;
                end
                else if (write_planes_reg != 4'b0000)
                begin
                    out_next.vram_write        = 1'b1;
                    out_next.vram_word_address = {page_select_reg, s1_offset_reg};
                    // Each data bit pair fills the low and high nibble pixel of one byte.
                    for (int k = 0; k < 4; k++)
                    begin
                        out_next.vram_data[8*k +: 8]     = {{4{s1_data_reg[6-2*k]}},
                                                            {4{s1_data_reg[7-2*k]}}} & mask_byte;
                        out_next.vram_bit_mask[8*k +: 8] = mask_byte;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= 1'b0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            write_planes_reg    <= '0;
            read_plane_reg      <= '0;
            page_select_reg     <= 1'b0;
            mix_value_reg       <= '0;
            font_rom_enable_reg <= 1'b0;
            jis_high_reg        <= '0;
            jis_low_reg         <= '0;
            font_offset_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg       <= 1'b1;
                write_planes_reg    <= write_planes_next;
                read_plane_reg      <= read_plane_next;
                page_select_reg     <= page_select_next;
                mix_value_reg       <= mix_value_next;
                font_rom_enable_reg <= font_rom_enable_next;
                jis_high_reg        <= jis_high_next;
                jis_low_reg         <= jis_low_next;
                font_offset_reg     <= font_offset_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_kind_reg   <= req.kind;
            s1_offset_reg <= req.offset;
            s1_data_reg   <= req.data;
        end
        if (s1_advance)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.read_data         = out_reg.read_data;
    assign rsp.rom_read          = out_reg.rom_read;
    assign rsp.rom_address       = out_reg.rom_address;
    assign rsp.ram_access        = out_reg.ram_access;
    assign rsp.ram_write         = out_reg.ram_write;
    assign rsp.ram_address       = out_reg.ram_address;
    assign rsp.vram_write        = out_reg.vram_write;
    assign rsp.vram_word_address = out_reg.vram_word_address;
    assign rsp.vram_data         = out_reg.vram_data;
    assign rsp.vram_bit_mask     = out_reg.vram_bit_mask;

`ifndef NO_ASSERTIONS
    // With the result register empty the input side can always take a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
        else $error("req.ready low while the result register is empty");

    // A result never both redirects to RAM and writes VRAM.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.vram_write && out_reg.ram_access))
        else $error("result drives both RAM and VRAM");

    // Main-memory mode leaves the register state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && mode_reg) |=>
            $stable(font_offset_reg) && $stable(write_planes_reg) && $stable(jis_high_reg))
        else $error("register state changed in main-memory mode");

    // Reading the second font byte advances the offset by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && !mode_reg && s1_kind_reg == KIND_REG_READ
            && s1_offset_reg == REG_FONT_RIGHT) |=>
            font_offset_reg == 17'($past(font_offset_reg) + 17'd1))
        else $error("font offset did not advance after second byte read");

    // A font ROM read reports no register data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.rom_read) |-> out_reg.read_data == 8'h00)
        else $error("ROM read carries register data");
`endif

endmodule

// ===== dv/planar_vram_and_font_address_regs_top_tb.sv =====
// ----------------------------------------------------------------------------
// planar_vram_and_font_address_regs_top_tb
// Self-checking bench for the planar VRAM and font address register block.
// A negedge driver feeds bus accesses from a queue with random gaps, and a
// posedge monitor decodes every accepted access in a local model of the
// register state and compares each result transfer field by field. The run
// goes through directed corner cases and random register, font and window
// traffic with main-memory mode both cleared and set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module planar_vram_and_font_address_regs_top_tb;
    import pvfa_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam logic [1:0]  KIND_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [14:0] offset;
        logic [7:0]  data;
    } access_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    pvfa_req_if req_bus ();
    pvfa_rsp_if rsp_bus ();

    planar_vram_and_font_address_regs_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Local copy of the register state.
    logic        mem_mode_m;
    logic [3:0]  write_planes_m;
    logic [1:0]  read_plane_m;
    logic        page_m;
    logic [7:0]  mix_m;
    logic        rom_en_m;
    logic [6:0]  jis_high_m;
    logic [6:0]  jis_low_m;
    logic [16:0] font_ofs_m;

    access_t    pending_q[$];
    pvfa_rsp_t  decoded_q[$];

    int unsigned items_queued;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned rom_reads;
    int unsigned ram_redirects;
    int unsigned vram_writes;
    int unsigned quiet_cycles;
    int unsigned send_gap;
    int unsigned stall_left;
    logic        req_taken;
    bit          no_idle;

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        if (quiet)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Font offset from the JIS code, in three row bands, wrapped to 17 bits.
    function automatic logic [16:0] jis_to_font_offset(input logic [6:0] hi,
                                                       input logic [6:0] lo);
        logic [6:0]  lo_b;
        logic [6:0]  hi_b;
        logic [31:0] outer;
        logic [31:0] acc;
        lo_b  = lo - JIS_LOW_BIAS;
        hi_b  = hi - JIS_BAND1_LOW;
        outer = (32'(lo[4:0]) << 4) | (32'(lo_b[5]) << 13) | (32'(lo_b[6]) << 12)
              | (32'(hi[2:0]) << 9);
        if (hi < JIS_BAND1_LOW)
            acc = outer;
        else if (hi < JIS_BAND2_LOW)
            acc = (32'(lo[4:0]) << 4) + (32'(lo_b[6:5]) << 13) + (32'(hi[3:0]) << 9)
                + 32'({hi_b[6:4], 4'b0000}) * 32'(FONT_ROW_STEP) + 32'(FONT_BAND1_BASE);
        else
            acc = outer | 32'(FONT_BAND2_BASE);
        return acc[16:0];
    endfunction

    // Decodes one accepted access, updates the local state and returns the
    // result the block should produce for it.
    function automatic pvfa_rsp_t decode_access(input logic [1:0] k,
                                                input logic [14:0] ofs,
                                                input logic [7:0] d);
        pvfa_rsp_t  r;
        logic [7:0] mbyte;
        logic [7:0] pix;
        r = '0;
        if (k == KIND_REG_WRITE || k == KIND_REG_READ)
        begin
            if (mem_mode_m)
            begin
                r.ram_access  = 1'b1;
                r.ram_write   = (k == KIND_REG_WRITE);
                r.ram_address = RAM_REG_BASE + 20'(ofs);
            end
            else if (k == KIND_REG_WRITE)
            begin
                case (ofs)
                    REG_MIX:      mix_m = d;
                    REG_PLANES:
                    begin
                        write_planes_m = d[3:0];
                        read_plane_m   = d[7:6];
                    end
                    REG_PAGE:     page_m = d[4];
                    REG_JIS_HIGH: jis_high_m = d[6:0];
                    REG_JIS_LOW:
                    begin
                        jis_low_m  = d[6:0];
                        font_ofs_m = jis_to_font_offset(jis_high_m, d[6:0]);
                    end
                    REG_ROM_EN:   rom_en_m = d[0];
                    default:      ;
                endcase
            end
            else
            begin
                case (ofs)
                    REG_MIX:    r.read_data = mix_m;
                    REG_PLANES: r.read_data = {read_plane_m, 2'b00, write_planes_m};
                    REG_PAGE:   r.read_data = page_m ? PAGE_READ_VALUE : 8'h00;
                    REG_FONT_LEFT:
                    begin
                        r.rom_read    = 1'b1;
                        r.rom_address = ROM_BASE + {3'b000, font_ofs_m, 1'b0};
                    end
                    REG_FONT_RIGHT:
                    begin
                        r.rom_read    = 1'b1;
                        r.rom_address = ROM_BASE + {3'b000, font_ofs_m, 1'b1};
                        font_ofs_m    = font_ofs_m + 17'd1;
                    end
                    REG_ROM_EN: r.read_data = {7'b0000000, rom_en_m};
                    default:    ;
                endcase
            end
        end
        else if (k == KIND_WIN_WRITE)
        begin
            if (mem_mode_m)
            begin
                r.ram_access  = 1'b1;
                r.ram_write   = 1'b1;
                r.ram_address = RAM_WIN_BASE + 20'(ofs);
            end
            else if (write_planes_m != 4'h0)
            begin
                mbyte = {write_planes_m, write_planes_m};
                r.vram_write        = 1'b1;
                r.vram_word_address = {page_m, ofs};
                // Each data bit pair lands on the two nibble pixels of one byte.
                for (int b = 0; b < 4; b++)
                begin
                    pix = {{4{d[6 - 2 * b]}}, {4{d[7 - 2 * b]}}};
                    r.vram_data[8 * b +: 8]     = pix & mbyte;
                    r.vram_bit_mask[8 * b +: 8] = mbyte;
                end
            end
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic compare_rsp(input pvfa_rsp_t want, input pvfa_rsp_t got);
        check_field("read_data", 32'(want.read_data), 32'(got.read_data));
        check_field("rom_read", 32'(want.rom_read), 32'(got.rom_read));
        check_field("rom_address", 32'(want.rom_address), 32'(got.rom_address));
        check_field("ram_access", 32'(want.ram_access), 32'(got.ram_access));
        check_field("ram_write", 32'(want.ram_write), 32'(got.ram_write));
        check_field("ram_address", 32'(want.ram_address), 32'(got.ram_address));
        check_field("vram_write", 32'(want.vram_write), 32'(got.vram_write));
        check_field("vram_word_address", 32'(want.vram_word_address),
                    32'(got.vram_word_address));
        check_field("vram_data", want.vram_data, got.vram_data);
        check_field("vram_bit_mask", want.vram_bit_mask, got.vram_bit_mask);
    endtask

    // Request driver: holds an item until its transfer, then waits out a gap.
    always @(negedge clk)
    begin
        access_t a;
        if (rst_n && !(req_bus.valid && !req_taken))
        begin
            if (send_gap != 0)
            begin
                send_gap      <= send_gap - 1;
                req_bus.valid <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                a = pending_q.pop_front();
                req_bus.valid  <= 1'b1;
                req_bus.kind   <= a.kind;
                req_bus.offset <= a.offset;
                req_bus.data   <= a.data;
                send_gap       <= pick_gap(no_idle);
            end
            else
            begin
                req_bus.valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            stall_left    <= pick_gap(no_idle);
            rsp_bus.ready <= 1'b1;
        end
    end

    // Monitor: checks result transfers, predicts accepted requests, and
    // ends the run when the handshakes stop moving.
    always @(posedge clk)
    begin
        pvfa_rsp_t got;
        bit        moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.read_data         = rsp_bus.read_data;
                got.rom_read          = rsp_bus.rom_read;
                got.rom_address       = rsp_bus.rom_address;
                got.ram_access        = rsp_bus.ram_access;
                got.ram_write         = rsp_bus.ram_write;
                got.ram_address       = rsp_bus.ram_address;
                got.vram_write        = rsp_bus.vram_write;
                got.vram_word_address = rsp_bus.vram_word_address;
                got.vram_data         = rsp_bus.vram_data;
                got.vram_bit_mask     = rsp_bus.vram_bit_mask;
                if (decoded_q.size() == 0)
                begin
                    $error("result transfer with no access outstanding");
                    mismatches++;
                end
                else
                begin
                    compare_rsp(decoded_q.pop_front(), got);
                end
                if (got.rom_read)   rom_reads++;
                if (got.ram_access) ram_redirects++;
                if (got.vram_write) vram_writes++;
                results_seen++;
                moved = 1'b1;
            end
            if (req_bus.valid && req_bus.ready)
            begin
                decoded_q.push_back(decode_access(req_bus.kind, req_bus.offset,
                                                  req_bus.data));
                moved = 1'b1;
            end
        end
        req_taken <= rst_n && req_bus.valid && req_bus.ready;
        if (moved)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_access(input logic [1:0] k, input logic [14:0] ofs,
                                input logic [7:0] d);
        access_t a;
        a.kind   = k;
        a.offset = ofs;
        a.data   = d;
        pending_q.push_back(a);
        items_queued++;
    endtask

    // Waits until every queued access has produced its result.
    task automatic drain();
        while (results_seen != items_queued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_mode(input logic v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        mem_mode_m = v;
    endtask

    function automatic logic [14:0] pick_reg();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20)
            return 15'($urandom_range(127));
        if (r < 30)
            return 15'($urandom_range(32767));
        case ($urandom_range(7))
            0:       return REG_MIX;
            1:       return REG_PLANES;
            2:       return REG_PAGE;
            3:       return REG_JIS_HIGH;
            4:       return REG_JIS_LOW;
            5:       return REG_FONT_LEFT;
            6:       return REG_FONT_RIGHT;
            default: return REG_ROM_EN;
        endcase
    endfunction

    task automatic queue_random(input int n);
        int left;
        int m;
        int unsigned r;
        left = n;
        while (left > 0)
        begin
            r = $urandom_range(99);
            if (r < 35)
            begin
                // Load a JIS code, then walk the font data.
                queue_access(KIND_REG_WRITE, REG_JIS_HIGH, 8'($urandom_range(255)));
                queue_access(KIND_REG_WRITE, REG_JIS_LOW, 8'($urandom_range(255)));
                m = $urandom_range(5, 1);
                repeat (m)
                    queue_access(KIND_REG_READ,
                                 $urandom_range(1) ? REG_FONT_RIGHT : REG_FONT_LEFT, 8'h00);
                left -= m + 2;
            end
            else if (r < 60)
            begin
                queue_access(KIND_REG_WRITE, REG_PLANES, 8'($urandom_range(255)));
                m = $urandom_range(4, 1);
                repeat (m)
                    queue_access(KIND_WIN_WRITE, 15'($urandom_range(32767)),
                                 8'($urandom_range(255)));
                left -= m + 1;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 35)
                    queue_access(KIND_REG_WRITE, pick_reg(), 8'($urandom_range(255)));
                else if (r < 65)
                    queue_access(KIND_REG_READ, pick_reg(), 8'($urandom_range(255)));
                else if (r < 95)
                    queue_access(KIND_WIN_WRITE, 15'($urandom_range(32767)),
                                 8'($urandom_range(255)));
                else
                    queue_access(KIND_UNUSED, 15'($urandom_range(32767)),
                                 8'($urandom_range(255)));
                left -= 1;
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        req_bus.valid  = 1'b0;
        req_bus.kind   = KIND_REG_WRITE;
        req_bus.offset = '0;
        req_bus.data   = '0;
        rsp_bus.ready  = 1'b0;
        req_taken      = 1'b0;
        send_gap       = 0;
        stall_left     = 0;
        no_idle        = 1'b0;
        items_queued   = 0;
        results_seen   = 0;
        mismatches     = 0;
        rom_reads      = 0;
        ram_redirects  = 0;
        vram_writes    = 0;
        quiet_cycles   = 0;
        mem_mode_m     = 1'b0;
        write_planes_m = '0;
        read_plane_m   = '0;
        page_m         = 1'b0;
        mix_m          = '0;
        rom_en_m       = 1'b0;
        jis_high_m     = '0;
        jis_low_m      = '0;
        font_ofs_m     = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        set_mode(1'b0);

        // Reset values, register extremes, unknown registers and the unused kind.
        queue_access(KIND_REG_READ, REG_PLANES, 8'hff);
        queue_access(KIND_REG_READ, REG_FONT_LEFT, 8'h00);
        queue_access(KIND_REG_READ, 15'h7fff, 8'h00);
        queue_access(KIND_UNUSED, 15'h7fff, 8'hff);
        queue_access(KIND_REG_WRITE, REG_MIX, 8'hff);
        queue_access(KIND_REG_READ, REG_MIX, 8'h00);
        queue_access(KIND_REG_WRITE, REG_PLANES, 8'hcf);
        queue_access(KIND_REG_WRITE, REG_PAGE, 8'hff);
        queue_access(KIND_REG_WRITE, REG_ROM_EN, 8'hff);
        queue_access(KIND_REG_READ, REG_PAGE, 8'h00);
        queue_access(KIND_REG_READ, REG_ROM_EN, 8'h00);
        queue_access(KIND_WIN_WRITE, 15'h7fff, 8'ha5);
        queue_access(KIND_REG_WRITE, REG_PLANES, 8'h00);
        queue_access(KIND_WIN_WRITE, 15'h0000, 8'hff);
        queue_access(KIND_REG_WRITE, REG_PLANES, 8'h05);
        queue_access(KIND_WIN_WRITE, 15'h2aaa, 8'h5a);
        // Font offsets at the band edges, and the offset auto-increment.
        queue_access(KIND_REG_WRITE, REG_JIS_HIGH, 8'hff);
        queue_access(KIND_REG_WRITE, REG_JIS_LOW, 8'hff);
        queue_access(KIND_REG_READ, REG_FONT_RIGHT, 8'h00);
        queue_access(KIND_REG_READ, REG_FONT_LEFT, 8'h00);
        queue_access(KIND_REG_WRITE, REG_JIS_HIGH, 8'h2f);
        queue_access(KIND_REG_WRITE, REG_JIS_LOW, 8'h20);
        queue_access(KIND_REG_WRITE, REG_JIS_HIGH, 8'h30);
        queue_access(KIND_REG_WRITE, REG_JIS_LOW, 8'h00);
        queue_access(KIND_REG_READ, REG_FONT_RIGHT, 8'h00);
        queue_access(KIND_REG_WRITE, REG_JIS_HIGH, 8'h6f);
        queue_access(KIND_REG_WRITE, REG_JIS_LOW, 8'h7f);
        queue_access(KIND_REG_READ, REG_FONT_LEFT, 8'h00);
        queue_access(KIND_REG_WRITE, 15'h7fff, 8'hff);
        drain();

        // Main-memory mode redirects everything and leaves the state alone.
        set_mode(1'b1);
        queue_access(KIND_REG_WRITE, 15'h7fff, 8'hff);
        queue_access(KIND_REG_WRITE, REG_MIX, 8'h00);
        queue_access(KIND_REG_READ, 15'h0000, 8'h00);
        queue_access(KIND_WIN_WRITE, 15'h7fff, 8'hff);
        queue_access(KIND_WIN_WRITE, 15'h0000, 8'h00);
        queue_access(KIND_UNUSED, 15'h0000, 8'h00);
        drain();

        set_mode(1'b0);
        queue_access(KIND_REG_READ, REG_MIX, 8'h00);
        queue_access(KIND_REG_READ, REG_PLANES, 8'h00);
        queue_access(KIND_REG_WRITE, REG_JIS_HIGH, 8'h70);
        queue_access(KIND_REG_WRITE, REG_JIS_LOW, 8'h5f);
        queue_access(KIND_REG_READ, REG_FONT_LEFT, 8'h00);
        queue_random(200);
        // The sender holds off here until every result is back.
        drain();
        queue_random(200);
        drain();

        set_mode(1'b1);
        no_idle = 1'b1;
        queue_random(100);
        drain();

        set_mode(1'b0);
        no_idle = 1'b0;
        queue_random(250);
        drain();
        repeat (8) @(negedge clk);

        if (decoded_q.size() != 0)
        begin
            $error("%0d expected results never arrived", decoded_q.size());
            mismatches++;
        end
        $display("Covered %0d accesses: %0d font ROM reads, %0d main RAM redirects,",
                 items_queued, rom_reads, ram_redirects);
        $display("%0d masked VRAM writes, main-memory mode off and on, %0d mismatches.",
                 vram_writes, mismatches);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
